// File: design/assert_macros.svh
// Assertion macros shared by the RTL of the task-file block.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// File: design/ata_pio_pkg.sv
// Types and constants shared by the ATA PIO task-file block.
// No dependencies; imported by ata_pio_task_file and the top level.
package ata_pio_pkg;

   localparam int ADDR_W     = 36;
   localparam int FULL_LBA_W = 28;
   localparam int DATA_W     = 16;
   localparam int BYTE_W     = 8;

   // task-file register numbers
   localparam logic [3:0] REG_DATA     = 4'd0;
   localparam logic [3:0] REG_ERROR    = 4'd1;
   localparam logic [3:0] REG_COUNT    = 4'd2;
   localparam logic [3:0] REG_LBA_LOW  = 4'd3;
   localparam logic [3:0] REG_LBA_MID  = 4'd4;
   localparam logic [3:0] REG_LBA_HIGH = 4'd5;
   localparam logic [3:0] REG_DRIVE    = 4'd6;
   localparam logic [3:0] REG_COMMAND  = 4'd7;

   // access kinds
   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   // command codes and status values
   localparam logic [7:0] CMD_READ_SECTORS  = 8'h20;
   localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;
   localparam logic [7:0] CMD_CACHE_FLUSH   = 8'hE7;
   localparam logic [7:0] STATUS_RDY        = 8'h40;
   localparam logic [7:0] STATUS_DRQ        = 8'h08;
   localparam logic [7:0] DRIVE_FIXED_BITS  = 8'hA0;

   // one bus access; last field in the lowest bits
   typedef struct packed {
      logic [DATA_W-1:0] byte_mask;
      logic [DATA_W-1:0] write_data;
      logic [3:0]        reg_index;
      logic              req_type;
   } ata_pio_req_type;

   // one result; last field in the lowest bits, padded to whole bytes
   typedef struct packed {
      logic              pad;
      logic              flush_request;
      logic [DATA_W-1:0] read_mask;
      logic [DATA_W-1:0] store_write_data;
      logic [ADDR_W-1:0] store_address;
      logic              store_write;
      logic              store_request;
      logic [BYTE_W-1:0] read_data;
   } ata_pio_rsp_type;

   typedef struct packed {
      logic store_issue;
      logic transfer_live;
   } ata_pio_status_type;

endpackage

// File: design/ata_pio_task_file.sv
// Task-file state registers and the per-access decode and update logic.
// Depends on ata_pio_pkg.
module ata_pio_task_file import ata_pio_pkg::*; #(
   parameter int HALF_WORDS_PER_SECTOR = 256,
   parameter int LBA_BITS              = 28
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  ata_pio_req_type    req,
   output ata_pio_rsp_type    rsp,
   output ata_pio_status_type status
);

   localparam int IDX_W = $clog2(HALF_WORDS_PER_SECTOR);
   localparam logic [IDX_W-1:0]  IDX_LAST    = IDX_W'(HALF_WORDS_PER_SECTOR - 1);
   localparam logic [ADDR_W-1:0] SECTOR_SPAN = ADDR_W'(HALF_WORDS_PER_SECTOR);

   logic [LBA_BITS-1:0] lba_ff, lba_in;
   logic [BYTE_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]   cmd_ff, cmd_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   logic [FULL_LBA_W-1:0] lba_full;
   logic [FULL_LBA_W-1:0] lba_work;
   logic [ADDR_W-1:0]     store_addr;
   logic [BYTE_W-1:0]     wbyte;
   logic [BYTE_W-1:0]     rval;
   logic                  active_rd;
   logic                  active_wr;
   logic                  advance;

   assign lba_full   = FULL_LBA_W'(lba_ff);
   assign active_rd  = (cmd_ff == CMD_READ_SECTORS) && (count_ff != '0);
   assign active_wr  = (cmd_ff == CMD_WRITE_SECTORS) && (count_ff != '0);
   assign store_addr = ADDR_W'(ADDR_W'(lba_ff) * SECTOR_SPAN) + ADDR_W'(idx_ff);
   assign wbyte      = req.write_data[BYTE_W-1:0];

   always_comb begin
      rsp      = '0;
      rval     = '0;
      advance  = 1'b0;
      lba_work = lba_full;
      count_in = count_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;

      if (req.req_type == ACC_READ) begin
         unique case (req.reg_index)
            REG_DATA: begin
               if (active_rd) begin
                  rsp.store_request = 1'b1;
                  rsp.store_address = store_addr;
                  rsp.read_mask     = req.byte_mask;
                  advance           = 1'b1;
               end
            end
            REG_COUNT:    rval = count_ff;
            REG_LBA_LOW:  rval = lba_full[7:0];
            REG_LBA_MID:  rval = lba_full[15:8];
            REG_LBA_HIGH: rval = lba_full[23:16];
            REG_DRIVE:    rval = DRIVE_FIXED_BITS | {4'b0000, lba_full[27:24]};
            REG_COMMAND:  rval = (active_rd || active_wr) ? STATUS_DRQ : STATUS_RDY;
            default:      rval = '0;
         endcase
         rsp.read_data = rval & req.byte_mask[BYTE_W-1:0];
      end else begin
         unique case (req.reg_index)
            REG_DATA: begin
               if (active_wr) begin
                  rsp.store_request    = 1'b1;
                  rsp.store_write      = 1'b1;
                  rsp.store_address    = store_addr;
                  rsp.store_write_data = req.write_data;
                  advance              = 1'b1;
               end
            end
            REG_COUNT:    count_in        = wbyte;
            REG_LBA_LOW:  lba_work[7:0]   = wbyte;
            REG_LBA_MID:  lba_work[15:8]  = wbyte;
            REG_LBA_HIGH: lba_work[23:16] = wbyte;
            REG_DRIVE:    lba_work[27:24] = wbyte[3:0];
            REG_COMMAND: begin
               cmd_in = wbyte;
               if (wbyte == CMD_READ_SECTORS || wbyte == CMD_WRITE_SECTORS) begin
                  idx_in = '0;
               end else if (wbyte == CMD_CACHE_FLUSH) begin
                  rsp.flush_request = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // step the index; at end of sector rewind it, drop count, step the LBA
      if (advance) begin
         if (idx_ff == IDX_LAST) begin
            idx_in   = '0;
            count_in = count_ff - BYTE_W'(1);
            lba_work = lba_full + FULL_LBA_W'(1);
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      lba_in = lba_work[LBA_BITS-1:0];
   end

   assign status.store_issue   = rsp.store_request;
   assign status.transfer_live = active_rd || active_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         lba_ff   <= '0;
         count_ff <= '0;
         cmd_ff   <= '0;
         idx_ff   <= '0;
      end else if (item_valid) begin
         lba_ff   <= lba_in;
         count_ff <= count_in;
         cmd_ff   <= cmd_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// File: design/ata_pio_disk_register_file_unit.sv
// ATA PIO task-file register block with 28-bit LBA: input beat register,
// task-file logic and result register. Depends on ata_pio_pkg,
// ata_pio_task_file and assert_macros.svh.
//
// One request beat is one bus access to a task-file register (data, error,
// sector count, LBA low/mid/high, drive, command/status). Every request beat
// gives exactly one response beat via the input beat and result registers;
// a new request is taken every cycle while rsp_tready is high: the task
// file updates as each item leaves the input register, so the next item
// sees the new state at once. Register writes build the block address and
// sector count and latch a command; read- and write-sectors commands rewind
// the half-word index, a cache-flush command gives a one-beat flush pulse.
// A data access under a matching command with a nonzero count issues one
// half-word storage request at LBA*HALF_WORDS_PER_SECTOR+index and steps the
// index; at the end of a sector the count drops and the LBA increments,
// wrapping at LBA_BITS. For a data read the storage half-word is masked
// outside the block with read_mask. Reset clears all task-file state.
`include "assert_macros.svh"

module ata_pio_disk_register_file_unit import ata_pio_pkg::*; #(
   parameter int HALF_WORDS_PER_SECTOR = 256,
   parameter int LBA_BITS              = 28
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // write_data[15:0], byte_mask[31:16]
   input  logic [4:0]  req_tuser,   // req_type[0], reg_index[4:1]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // read_data[7:0], store_request[8],
                                    // store_write[9], store_address[45:10],
                                    // store_write_data[61:46],
                                    // read_mask[77:62], flush_request[78],
                                    // zero pad[79]
);

   logic               req_accept;
   logic               out_ready;
   logic               s1_adv;

   logic               s1_valid_ff, s1_valid_in;
   ata_pio_req_type    s1_req_ff, s1_req_in;
   logic               out_valid_ff, out_valid_in;
   ata_pio_rsp_type    out_rsp_ff, out_rsp_in;

   ata_pio_rsp_type    core_rsp;
   ata_pio_status_type core_status;

   // the result register frees up when empty or when its beat is taken
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_accept = req_tvalid && req_tready;

   // unpack the request beat
   always_comb begin
      s1_req_in.req_type   = req_tuser[0];
      s1_req_in.reg_index  = req_tuser[4:1];
      s1_req_in.write_data = req_tdata[15:0];
      s1_req_in.byte_mask  = req_tdata[31:16];
   end

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      out_rsp_in = core_rsp;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // task-file state advances only as an item moves into the result register
   ata_pio_task_file #(
      .HALF_WORDS_PER_SECTOR (HALF_WORDS_PER_SECTOR),
      .LBA_BITS              (LBA_BITS)
   ) u_task_file (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_adv),
      .req        (s1_req_ff),
      .rsp        (core_rsp),
      .status     (core_status)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: hold unless a new beat loads
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= s1_req_in;
      end
      if (s1_adv) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_rsp_ff;

   // an item leaving the input register always lands in the result register
   `ASSERT_CLK(a_adv_fills_out, s1_adv |=> rsp_tvalid, "advanced item lost")
   // a storage access is only issued while a transfer is live
   `ASSERT_CLK(a_store_needs_xfer,
      (s1_adv && core_status.store_issue) |-> core_status.transfer_live,
      "storage access without a live transfer")
   // a flush pulse never rides on a storage access beat
   `ASSERT_NEVER(a_flush_vs_store,
      rsp_tvalid && out_rsp_ff.store_request && out_rsp_ff.flush_request,
      "flush and storage access in one beat")

endmodule

// File: dv/ata_pio_task_file_checker.sv
// Scoreboard for the ATA PIO task-file block: watches both stream channels,
// predicts each response beat and compares it field by field.
// Depends on ata_pio_pkg for the beat layout, register numbers and codes.
module ata_pio_task_file_checker
   import ata_pio_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // write_data[15:0], byte_mask[31:16]
   input  logic [4:0]  req_tuser,   // req_type[0], reg_index[4:1]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,   // ata_pio_rsp_type, read_data lowest
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECTOR_HALF_WORDS = 256;
   localparam int LBA_WIDTH         = 28;

   // task-file image
   logic [LBA_WIDTH-1:0] lba_reg;
   logic [7:0]           count_reg;
   logic [7:0]           cmd_reg;
   logic [7:0]           hw_index;

   ata_pio_rsp_type awaited_beats[$];
   int              mismatch_count;

   assign fail_count = mismatch_count;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [35:0] got,
                              input logic [35:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   function automatic bit transfer_live(input logic [7:0] code);
      return cmd_reg == code && count_reg != 8'd0;
   endfunction

   // advance the half-word pointer; roll to the next sector at the end
   function automatic void step_index();
      hw_index = hw_index + 8'd1;
      if (hw_index == 8'd0 || int'(hw_index) >= SECTOR_HALF_WORDS) begin
         hw_index  = 8'd0;
         count_reg = count_reg - 8'd1;
         lba_reg   = lba_reg + LBA_WIDTH'(1);
      end
   endfunction

   // one bus access against the task-file image; returns the response beat
   function automatic ata_pio_rsp_type apply_bus_access(input logic acc,
         input logic [3:0] reg_no, input logic [15:0] wdata,
         input logic [15:0] mask);
      ata_pio_rsp_type  beat;
      logic [7:0]       rval;
      logic [7:0]       wbyte;
      logic [ADDR_W-1:0] addr;
      beat  = '0;
      rval  = 8'h00;
      wbyte = wdata[7:0];
      addr  = ADDR_W'(lba_reg) * ADDR_W'(SECTOR_HALF_WORDS) + ADDR_W'(hw_index);
      if (acc == ACC_READ) begin
         case (reg_no)
            REG_DATA: begin
               if (transfer_live(CMD_READ_SECTORS)) begin
                  beat.store_request = 1'b1;
                  beat.store_address = addr;
                  beat.read_mask     = mask;
                  step_index();
               end
            end
            REG_COUNT:    rval = count_reg;
            REG_LBA_LOW:  rval = lba_reg[7:0];
            REG_LBA_MID:  rval = lba_reg[15:8];
            REG_LBA_HIGH: rval = lba_reg[23:16];
            REG_DRIVE:    rval = DRIVE_FIXED_BITS | {4'h0, lba_reg[27:24]};
            REG_COMMAND:  rval = (transfer_live(CMD_READ_SECTORS) ||
                                  transfer_live(CMD_WRITE_SECTORS)) ? STATUS_DRQ
                                                                    : STATUS_RDY;
            default:      rval = 8'h00;
         endcase
         beat.read_data = rval & mask[7:0];
      end else begin
         case (reg_no)
            REG_DATA: begin
               if (transfer_live(CMD_WRITE_SECTORS)) begin
                  beat.store_request    = 1'b1;
                  beat.store_write      = 1'b1;
                  beat.store_address    = addr;
                  beat.store_write_data = wdata;
                  step_index();
               end
            end
            REG_COUNT:    count_reg       = wbyte;
            REG_LBA_LOW:  lba_reg[7:0]    = wbyte;
            REG_LBA_MID:  lba_reg[15:8]   = wbyte;
            REG_LBA_HIGH: lba_reg[23:16]  = wbyte;
            REG_DRIVE:    lba_reg[27:24]  = wbyte[3:0];
            REG_COMMAND: begin
               cmd_reg = wbyte;
               if (wbyte == CMD_READ_SECTORS || wbyte == CMD_WRITE_SECTORS)
                  hw_index = 8'd0;
               else if (wbyte == CMD_CACHE_FLUSH)
                  beat.flush_request = 1'b1;
            end
            default: ;
         endcase
      end
      return beat;
   endfunction

   always @(posedge clock) begin : watch
      ata_pio_rsp_type got;
      ata_pio_rsp_type want;
      if (reset) begin
         lba_reg   = '0;
         count_reg = '0;
         cmd_reg   = '0;
         hw_index  = '0;
         awaited_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = ata_pio_rsp_type'(rsp_tdata);
            if (awaited_beats.size() == 0) begin
               report_mismatch($sformatf("response beat %h with nothing awaited",
                                         rsp_tdata));
            end else begin
               want = awaited_beats.pop_front();
               check_field("read_data", got.read_data, want.read_data);
               check_field("store_request", got.store_request, want.store_request);
               check_field("store_write", got.store_write, want.store_write);
               check_field("store_address", got.store_address, want.store_address);
               check_field("store_write_data", got.store_write_data,
                           want.store_write_data);
               check_field("read_mask", got.read_mask, want.read_mask);
               check_field("flush_request", got.flush_request, want.flush_request);
               check_field("pad", got.pad, want.pad);
            end
         end
         if (req_tvalid && req_tready)
            awaited_beats.push_back(apply_bus_access(req_tuser[0], req_tuser[4:1],
                                                     req_tdata[15:0],
                                                     req_tdata[31:16]));
      end
      pending <= awaited_beats.size();
   end

endmodule

// File: dv/testbench.sv
// Top of the task-file testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on ata_pio_pkg, the block itself
// and ata_pio_task_file_checker, which does all prediction and comparison.
module testbench;
   import ata_pio_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] REG_UNUSED_LOW  = 4'd8;
   localparam logic [3:0] REG_UNUSED_HIGH = 4'd15;
   localparam logic [7:0] CMD_IDLE        = 8'h00;
   localparam int         RANDOM_ITEMS    = 1200;
   localparam int         LONG_HOLD       = 300;
   localparam int         SETTLE_CYCLES   = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // write_data[15:0], byte_mask[31:16]
   logic [4:0]  req_tuser = '0;   // req_type[0], reg_index[4:1]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // read_data[7:0] ... flush_request[78], pad[79]

   int fail_count;
   int pending;
   int items_sent = 0;

   // steering between the stimulus and the response sink
   bit hold_responses = 1'b0;
   bit no_idle        = 1'b0;

   ata_pio_disk_register_file_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ata_pio_task_file_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Mostly back-to-back, now and then a short gap, rarely a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Byte value biased towards the all-zeros and all-ones extremes.
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return 8'h00;
      if (r < 30)
         return 8'hFF;
      return 8'($urandom);
   endfunction

   // Offer one request beat and hold it until the block takes it. Drop valid
   // only when a gap is wanted, so a back-to-back beat never sees valid
   // lowered and raised in the same step.
   task automatic bus_access(input logic acc, input logic [3:0] reg_no,
                             input logic [15:0] wdata, input logic [15:0] mask);
      int gap;
      gap = no_idle ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mask, wdata};
      req_tuser  <= {reg_no, acc};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Register write with noise in the unused upper byte and the write mask.
   task automatic reg_write(input logic [3:0] reg_no, input logic [7:0] value);
      bus_access(ACC_WRITE, reg_no, {8'($urandom), value}, 16'($urandom));
   endtask

   task automatic reg_read(input logic [3:0] reg_no);
      bus_access(ACC_READ, reg_no, 16'($urandom), 16'($urandom));
   endtask

   // A well-formed transfer: program count, LBA and command, then a run of
   // data beats in the matching direction with status and address polls and
   // the odd wrong-direction beat mixed in. The wrap case starts from the top
   // LBA so that the end of the sector rolls the address over 28 bits.
   task automatic sector_run(input bit wrap_case);
      logic       dir;
      logic [7:0] cnt;
      logic [7:0] cmd;
      int         run_len;
      int         r;
      dir = 1'($urandom_range(0, 1));
      r   = $urandom_range(0, 99);
      if (wrap_case)
         cnt = 8'($urandom_range(1, 2));
      else if (r < 8)
         cnt = 8'h00;
      else if (r < 14)
         cnt = 8'hFF;
      else
         cnt = 8'($urandom_range(1, 3));
      if (wrap_case || $urandom_range(0, 3) != 0)
         reg_write(REG_COUNT, cnt);
      if (wrap_case) begin
         reg_write(REG_LBA_LOW, 8'hFF);
         reg_write(REG_LBA_MID, 8'hFF);
         reg_write(REG_LBA_HIGH, 8'hFF);
         reg_write(REG_DRIVE, {4'($urandom), 4'hF});
      end else begin
         if ($urandom_range(0, 3) != 0)
            reg_write(REG_LBA_LOW, pick_byte());
         if ($urandom_range(0, 3) != 0)
            reg_write(REG_LBA_MID, pick_byte());
         if ($urandom_range(0, 3) != 0)
            reg_write(REG_LBA_HIGH, pick_byte());
         if ($urandom_range(0, 3) != 0)
            reg_write(REG_DRIVE, pick_byte());
      end
      r = $urandom_range(0, 99);
      if (!wrap_case && r < 5)
         cmd = CMD_CACHE_FLUSH;
      else if (!wrap_case && r < 10)
         cmd = 8'($urandom);
      else
         cmd = dir ? CMD_WRITE_SECTORS : CMD_READ_SECTORS;
      reg_write(REG_COMMAND, cmd);
      if (wrap_case || $urandom_range(0, 99) >= 88)
         run_len = $urandom_range(250, 520);
      else
         run_len = $urandom_range(1, 40);
      repeat (run_len) begin
         r = $urandom_range(0, 99);
         if (r < 12)
            reg_read(4'($urandom_range(REG_COUNT, REG_COMMAND)));
         else if (r < 16)
            bus_access(dir ? ACC_READ : ACC_WRITE, REG_DATA, 16'($urandom),
                       16'($urandom));
         else
            bus_access(dir ? ACC_WRITE : ACC_READ, REG_DATA, 16'($urandom),
                       16'($urandom));
      end
   endtask

   // Response sink: random ready bursts and gaps, a long hold-off when the
   // stimulus asks for one, and ready held high through the no-idle stretch.
   initial begin : response_sink
      int burst;
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_responses) begin
            // hold off long enough to fill the block and stall its input
            hold_responses <= 1'b0;
            rsp_tready     <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            burst = $urandom_range(1, 8);
            rsp_tready <= 1'b1;
            repeat (burst) @(posedge clock);
            gap = idle_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      bit pressure_done;
      bit drain_done;
      int target;
      int r;
      pressure_done = 1'b0;
      drain_done    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle status, dead data beats, extreme LBA and count,
      // masked reads, error and unused registers, every command.
      bus_access(ACC_READ,  REG_COMMAND,     16'h0000, 16'hFFFF);
      bus_access(ACC_READ,  REG_DATA,        16'h0000, 16'hFFFF);
      bus_access(ACC_WRITE, REG_DATA,        16'hFFFF, 16'hFFFF);
      bus_access(ACC_WRITE, REG_COUNT,       16'hFF01, 16'h0000);
      bus_access(ACC_WRITE, REG_LBA_LOW,     16'hFFFF, 16'h0000);
      bus_access(ACC_WRITE, REG_LBA_MID,     16'hFFFF, 16'h0000);
      bus_access(ACC_WRITE, REG_LBA_HIGH,    16'hFFFF, 16'h0000);
      bus_access(ACC_WRITE, REG_DRIVE,       16'hFFFF, 16'h0000);
      bus_access(ACC_READ,  REG_DRIVE,       16'h0000, 16'hFFFF);
      bus_access(ACC_READ,  REG_LBA_HIGH,    16'hFFFF, 16'h0000);
      bus_access(ACC_READ,  REG_LBA_MID,     16'h0000, 16'h00FF);
      bus_access(ACC_READ,  REG_COUNT,       16'h0000, 16'hFF0F);
      bus_access(ACC_WRITE, REG_ERROR,       16'hFFFF, 16'hFFFF);
      bus_access(ACC_READ,  REG_ERROR,       16'hFFFF, 16'hFFFF);
      bus_access(ACC_READ,  REG_UNUSED_LOW,  16'hFFFF, 16'hFFFF);
      bus_access(ACC_WRITE, REG_UNUSED_HIGH, 16'hFFFF, 16'hFFFF);
      bus_access(ACC_READ,  REG_UNUSED_HIGH, 16'h0000, 16'hFFFF);
      bus_access(ACC_WRITE, REG_COMMAND,     {8'hFF, CMD_CACHE_FLUSH}, 16'hFFFF);
      bus_access(ACC_WRITE, REG_COMMAND,     {8'h00, CMD_WRITE_SECTORS}, 16'h0000);
      bus_access(ACC_READ,  REG_COMMAND,     16'h0000, 16'hFFFF);
      bus_access(ACC_WRITE, REG_DATA,        16'hFFFF, 16'h0000);
      bus_access(ACC_WRITE, REG_COMMAND,     {8'hFF, CMD_READ_SECTORS}, 16'h0000);
      bus_access(ACC_READ,  REG_DATA,        16'hFFFF, 16'hFFFF);
      bus_access(ACC_READ,  REG_DATA,        16'h0000, 16'h0000);
      bus_access(ACC_WRITE, REG_COUNT,       16'h0000, 16'h0000);
      bus_access(ACC_READ,  REG_DATA,        16'hFFFF, 16'hFFFF);
      bus_access(ACC_WRITE, REG_COMMAND,     {8'h00, CMD_IDLE}, 16'h0000);
      bus_access(ACC_READ,  REG_COMMAND,     16'h0000, 16'hFFFF);

      // Random: mostly well-formed transfers, with noise beats in between.
      target = items_sent + RANDOM_ITEMS;
      sector_run(1'b1);
      while (items_sent < target) begin
         if (!pressure_done && items_sent >= target - 800) begin
            hold_responses <= 1'b1;
            pressure_done = 1'b1;
         end
         if (!drain_done && items_sent >= target - 400) begin
            // drop valid and wait for every outstanding response
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending != 0);
            drain_done = 1'b1;
         end
         no_idle <= (items_sent >= target - 250 && items_sent < target - 150);
         r = $urandom_range(0, 99);
         if (r < 80) begin
            sector_run($urandom_range(0, 15) == 0);
         end else begin
            repeat ($urandom_range(1, 5))
               bus_access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                          16'($urandom), 16'($urandom));
         end
      end
      req_tvalid <= 1'b0;
      no_idle    <= 1'b0;

      // Drain, then give stray beats a chance to show up.
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
